// ===== rtl/core/lobm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lobm_pkg
// Types and codes shared by the order book matcher modules.
// ----------------------------------------------------------------------------
package lobm_pkg;

  localparam int TRADES_W = 6;

  localparam logic [2:0] OPC_LIMIT  = 3'd0;
  localparam logic [2:0] OPC_MARKET = 3'd1;
  localparam logic [2:0] OPC_CANCEL = 3'd2;
  localparam logic [2:0] OPC_MODIFY = 3'd3;
  localparam logic [2:0] OPC_CLEAR  = 3'd4;

  localparam logic [2:0] ST_ACCEPTED  = 3'd0;
  localparam logic [2:0] ST_PARTIAL   = 3'd1;
  localparam logic [2:0] ST_FILLED    = 3'd2;
  localparam logic [2:0] ST_REJECTED  = 3'd3;
  localparam logic [2:0] ST_CANCELLED = 3'd4;
  localparam logic [2:0] ST_MODIFIED  = 3'd5;
  localparam logic [2:0] ST_NOT_FOUND = 3'd6;

  typedef enum logic [2:0] {
    KIND_LIMIT,
    KIND_MARKET,
    KIND_CANCEL,
    KIND_MODIFY,
    KIND_CLEAR,
    KIND_BAD
  } op_kind_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_CHECK,
    S_TRADE,
    S_AFTER,
    S_REST,
    S_RESP
  } eng_state_t;

  typedef enum logic [1:0] {
    PH_FIND,
    PH_MATCH,
    PH_FINAL
  } scan_phase_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] ord_id;
    logic [31:0] owner_id;
    logic        side;
    logic [31:0] price;
    logic [31:0] qty;
  } req_t;

  typedef struct packed {
    logic                is_trade;
    logic [31:0]         subject_ord_id;
    logic [31:0]         maker_ord_id;
    logic [31:0]         maker_owner_id;
    logic [31:0]         trade_price;
    logic [31:0]         fill_amt;
    logic [2:0]          status;
    logic [31:0]         qty_left;
    logic [TRADES_W-1:0] trades_made;
    logic [31:0]         top_bid;
    logic [31:0]         top_ask;
    logic                last;
  } rsp_t;

  typedef struct packed {
    op_kind_t    kind;
    logic [31:0] ord_id;
    logic [31:0] owner_id;
    logic        side;
    logic [31:0] price;
    logic [31:0] qty;
  } cmd_t;

endpackage

// ===== rtl/core/lobm_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lobm_front
// Takes requests, decodes the op code and queues commands for the engine.
// ----------------------------------------------------------------------------
module lobm_front import lobm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic cmd_valid,
  input  logic cmd_take,
  output cmd_t cmd
);

  cmd_t       queue [2];
  logic       wp;
  logic       rp;
  logic [1:0] count;
  cmd_t       decoded;
  logic       push;
  logic       pop;

  always_comb begin
    decoded.ord_id   = req.ord_id;
    decoded.owner_id = req.owner_id;
    decoded.side     = req.side;
    decoded.price    = req.price;
    decoded.qty      = req.qty;
    case (req.op)
      OPC_LIMIT:  decoded.kind = KIND_LIMIT;
      OPC_MARKET: decoded.kind = KIND_MARKET;
      OPC_CANCEL: decoded.kind = KIND_CANCEL;
      OPC_MODIFY: decoded.kind = KIND_MODIFY;
      OPC_CLEAR:  decoded.kind = KIND_CLEAR;
      default:    decoded.kind = KIND_BAD;
    endcase
  end

  assign req_stall = (count == 2'd2);
  assign push      = req_valid && !req_stall;
  assign cmd_valid = (count != 2'd0);
  assign pop       = cmd_take && cmd_valid;
  assign cmd       = queue[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wp] <= decoded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== rtl/core/lobm_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lobm_engine
// Slot table, scan unit and matching sequencer with the result register.
// ----------------------------------------------------------------------------
module lobm_engine import lobm_pkg::*; #(
  parameter int ORDER_SLOTS = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_take,
  input  cmd_t cmd,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  localparam int SW = (ORDER_SLOTS > 1) ? $clog2(ORDER_SLOTS) : 1;
  localparam int CW = $clog2(ORDER_SLOTS + 1);
  localparam logic [CW-1:0]       LAST_CNT = CW'(ORDER_SLOTS);
  localparam logic [TRADES_W-1:0] MAX_N    = TRADES_W'(ORDER_SLOTS);

  // slot table
  logic [31:0] mem_oid   [ORDER_SLOTS];
  logic [31:0] mem_tid   [ORDER_SLOTS];
  logic [31:0] mem_price [ORDER_SLOTS];
  logic [31:0] mem_qty   [ORDER_SLOTS];
  logic        mem_side  [ORDER_SLOTS];
  logic [63:0] mem_arr   [ORDER_SLOTS];
  logic [ORDER_SLOTS-1:0] slot_valid;
  logic [63:0] arrival;

  eng_state_t  state, state_next;
  scan_phase_t phase, phase_next;

  // scan read pipe
  logic [CW-1:0] cnt;
  logic          pipe_v;
  logic [SW-1:0] rd_idx;
  logic          rd_valid;
  logic [31:0]   rd_oid, rd_tid, rd_price, rd_qty;
  logic          rd_side;
  logic [63:0]   rd_arr;

  // request and working values
  op_kind_t      kind;
  logic [31:0]   oid, q_tid, q_price, q_qty;
  logic          q_side;
  logic          market;
  logic          t_side;
  logic [31:0]   t_price, t_tid;
  logic [31:0]   rem;
  logic [TRADES_W-1:0] n;
  logic [2:0]    st;
  logic [31:0]   filled, left;

  // scan results
  logic          fnd;
  logic [SW-1:0] fnd_idx;
  logic [31:0]   fnd_tid, fnd_price, fnd_qty;
  logic          fnd_side;
  logic          free_ok;
  logic [SW-1:0] free_idx;
  logic [1:0]    b_ok;
  logic [SW-1:0] b_idx   [2];
  logic [31:0]   b_price [2];
  logic [63:0]   b_arr   [2];
  logic [31:0]   b_qty   [2];
  logic [31:0]   b_oid   [2];
  logic [31:0]   b_tid   [2];

  logic        scan_start, scan_done, rd_en;
  logic        load_ok, opp, cross_ok, better;
  logic [31:0] m_price, m_qty, fill, m_left, rem_left;

  // decide outputs
  logic        dec_match, dec_inval, dec_qty_wr, dec_clear, dec_market, dec_side;
  logic [31:0] dec_price, dec_tid, dec_left;
  logic [2:0]  dec_st;

  // memory write controls
  logic          rest_we, qty_we;
  logic [SW-1:0] qty_addr;
  logic [31:0]   qty_data;

  // next result transfer
  logic          rsp_load;
  rsp_t          rsp_next;

  assign load_ok   = !rsp_valid || !rsp_stall;
  assign opp       = ~t_side;
  assign m_price   = b_price[opp];
  assign m_qty     = b_qty[opp];
  assign fill      = (rem < m_qty) ? rem : m_qty;
  assign m_left    = m_qty - fill;
  assign rem_left  = rem - fill;
  assign cross_ok  = market || (t_side ? (m_price >= t_price) : (m_price <= t_price));
  assign rd_en     = (state == S_SCAN) && (cnt != LAST_CNT);
  assign scan_done = (state == S_SCAN) && (cnt == LAST_CNT) && !pipe_v;
  assign scan_start = (state_next == S_SCAN) && (state != S_SCAN);
  assign rsp_load  = load_ok && ((state == S_TRADE) || (state == S_RESP));

  always_comb begin
    if (!b_ok[rd_side]) begin
      better = 1'b1;
    end else if (rd_price != b_price[rd_side]) begin
      better = rd_side ? (rd_price < b_price[rd_side]) : (rd_price > b_price[rd_side]);
    end else begin
      better = rd_arr < b_arr[rd_side];
    end
  end

  always_comb begin
    dec_match  = 1'b0;
    dec_inval  = 1'b0;
    dec_qty_wr = 1'b0;
    dec_clear  = 1'b0;
    dec_market = 1'b0;
    dec_side   = q_side;
    dec_price  = q_price;
    dec_tid    = q_tid;
    dec_left   = 32'd0;
    dec_st     = ST_REJECTED;
    case (kind)
      KIND_LIMIT: begin
        dec_match = !fnd;
      end
      KIND_MARKET: begin
        dec_match  = 1'b1;
        dec_market = 1'b1;
      end
      KIND_CANCEL: begin
        if (!fnd) begin
          dec_st = ST_NOT_FOUND;
        end else begin
          dec_inval = 1'b1;
          dec_left  = fnd_qty;
          dec_st    = ST_CANCELLED;
        end
      end
      KIND_MODIFY: begin
        dec_side = fnd_side;
        dec_tid  = fnd_tid;
        if (!fnd) begin
          dec_st = ST_NOT_FOUND;
        end else if (q_price != 32'd0 && q_price != fnd_price) begin
          dec_inval = 1'b1;
          dec_match = 1'b1;
        end else if (q_qty == 32'd0) begin
          dec_inval = 1'b1;
          dec_left  = fnd_qty;
          dec_st    = ST_CANCELLED;
        end else if (q_qty < fnd_qty) begin
          dec_qty_wr = 1'b1;
          dec_left   = q_qty;
          dec_st     = ST_MODIFIED;
        end else begin
          dec_inval = 1'b1;
          dec_match = 1'b1;
          dec_price = fnd_price;
        end
      end
      KIND_CLEAR: begin
        dec_clear = 1'b1;
        dec_st    = ST_ACCEPTED;
      end
      default: begin
        dec_st = ST_REJECTED;
      end
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    phase_next = phase;
    case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          state_next = S_SCAN;
          phase_next = PH_FIND;
        end
      end
      S_SCAN: begin
        if (scan_done) begin
          case (phase)
            PH_FIND:  state_next = S_DECIDE;
            PH_MATCH: state_next = S_CHECK;
            default:  state_next = S_RESP;
          endcase
        end
      end
      S_DECIDE: begin
        if (dec_match && q_qty == 32'd0) begin
          state_next = S_AFTER;
        end else begin
          state_next = S_SCAN;
          phase_next = dec_match ? PH_MATCH : PH_FINAL;
        end
      end
      S_CHECK: begin
        if (!b_ok[opp] || !cross_ok || n == MAX_N) begin
          state_next = S_AFTER;
        end else begin
          state_next = S_TRADE;
        end
      end
      S_TRADE: begin
        if (load_ok) begin
          if (rem_left == 32'd0) begin
            state_next = S_AFTER;
          end else begin
            state_next = S_SCAN;
            phase_next = PH_MATCH;
          end
        end
      end
      S_AFTER: begin
        if (!market && rem != 32'd0 && free_ok) begin
          state_next = S_REST;
        end else begin
          state_next = S_SCAN;
          phase_next = PH_FINAL;
        end
      end
      S_REST: begin
        state_next = S_SCAN;
        phase_next = PH_FINAL;
      end
      S_RESP: begin
        if (load_ok) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    cmd_take = (state == S_IDLE) && cmd_valid;
    rest_we  = (state == S_REST);
    qty_we   = 1'b0;
    qty_addr = free_idx;
    qty_data = rem;
    case (state)
      S_DECIDE: begin
        qty_we   = dec_qty_wr;
        qty_addr = fnd_idx;
        qty_data = q_qty;
      end
      S_TRADE: begin
        qty_we   = load_ok;
        qty_addr = b_idx[opp];
        qty_data = m_left;
      end
      S_REST: begin
        qty_we = 1'b1;
      end
      default: begin
        qty_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= PH_FIND;
    end else begin
      state <= state_next;
      phase <= phase_next;
    end
  end

  // slot table storage
  always_ff @(posedge clk) begin
    if (rest_we) begin
      mem_oid[free_idx]   <= oid;
      mem_tid[free_idx]   <= t_tid;
      mem_price[free_idx] <= t_price;
      mem_side[free_idx]  <= t_side;
      mem_arr[free_idx]   <= arrival;
    end
    if (qty_we) begin
      mem_qty[qty_addr] <= qty_data;
    end
    if (rd_en) begin
      rd_oid   <= mem_oid[cnt[SW-1:0]];
      rd_tid   <= mem_tid[cnt[SW-1:0]];
      rd_price <= mem_price[cnt[SW-1:0]];
      rd_qty   <= mem_qty[cnt[SW-1:0]];
      rd_side  <= mem_side[cnt[SW-1:0]];
      rd_arr   <= mem_arr[cnt[SW-1:0]];
      rd_valid <= slot_valid[cnt[SW-1:0]];
      rd_idx   <= cnt[SW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      arrival    <= 64'd0;
    end else begin
      if (state == S_DECIDE && dec_clear) begin
        slot_valid <= '0;
      end
      if (state == S_DECIDE && dec_inval) begin
        slot_valid[fnd_idx] <= 1'b0;
      end
      if (state == S_TRADE && load_ok && m_left == 32'd0) begin
        slot_valid[b_idx[opp]] <= 1'b0;
      end
      if (rest_we) begin
        slot_valid[free_idx] <= 1'b1;
        arrival              <= arrival + 64'd1;
      end
    end
  end

  // scan unit
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= '0;
      pipe_v <= 1'b0;
    end else if (scan_start) begin
      cnt    <= '0;
      pipe_v <= 1'b0;
    end else begin
      pipe_v <= rd_en;
      if (rd_en) begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (scan_start) begin
      fnd     <= 1'b0;
      free_ok <= 1'b0;
      b_ok    <= 2'b00;
    end else if (pipe_v) begin
      if (rd_valid && rd_oid == oid && !fnd) begin
        fnd       <= 1'b1;
        fnd_idx   <= rd_idx;
        fnd_tid   <= rd_tid;
        fnd_side  <= rd_side;
        fnd_price <= rd_price;
        fnd_qty   <= rd_qty;
      end
      if (!rd_valid && !free_ok) begin
        free_ok  <= 1'b1;
        free_idx <= rd_idx;
      end
      if (rd_valid && better) begin
        b_ok[rd_side]    <= 1'b1;
        b_idx[rd_side]   <= rd_idx;
        b_price[rd_side] <= rd_price;
        b_arr[rd_side]   <= rd_arr;
        b_qty[rd_side]   <= rd_qty;
        b_oid[rd_side]   <= rd_oid;
        b_tid[rd_side]   <= rd_tid;
      end
    end
  end

  // request registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        kind    <= cmd.kind;
        oid     <= cmd.ord_id;
        q_tid   <= cmd.owner_id;
        q_side  <= cmd.side;
        q_price <= cmd.price;
        q_qty   <= cmd.qty;
        market  <= 1'b0;
        n       <= '0;
        filled  <= 32'd0;
      end
      S_DECIDE: begin
        st      <= dec_st;
        left    <= dec_left;
        market  <= dec_market;
        t_side  <= dec_side;
        t_price <= dec_price;
        t_tid   <= dec_tid;
        rem     <= q_qty;
      end
      S_TRADE: begin
        if (load_ok) begin
          rem <= rem_left;
          n   <= n + 1'b1;
        end
      end
      S_AFTER: begin
        filled <= q_qty - rem;
        left   <= rem;
        if (rem == 32'd0) begin
          st <= ST_FILLED;
        end else if (market) begin
          st <= ST_PARTIAL;
        end else if (!free_ok) begin
          st <= ST_REJECTED;
        end else begin
          st <= (n != '0) ? ST_PARTIAL : ST_ACCEPTED;
        end
      end
      default: begin
        st <= st;
      end
    endcase
  end

  // result register
  always_comb begin
    rsp_next = '0;
    rsp_next.subject_ord_id = oid;
    if (state == S_TRADE) begin
      rsp_next.is_trade       = 1'b1;
      rsp_next.maker_ord_id   = b_oid[opp];
      rsp_next.maker_owner_id = b_tid[opp];
      rsp_next.trade_price    = m_price;
      rsp_next.fill_amt       = fill;
      rsp_next.status         = ST_ACCEPTED;
    end else begin
      rsp_next.fill_amt    = filled;
      rsp_next.status      = st;
      rsp_next.qty_left    = left;
      rsp_next.trades_made = n;
      rsp_next.top_bid     = b_ok[0] ? b_price[0] : 32'd0;
      rsp_next.top_ask     = b_ok[1] ? b_price[1] : 32'd0;
      rsp_next.last        = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp <= rsp_next;
    end
  end

endmodule

// ===== rtl/core/limit_order_book_matcher.sv =====
`timescale 1ns / 1ps
// Every pass over the slot table reads one slot per cycle from the single table
// read port. A request passes once to look up its id, then, if it matches, once
// before every fill and once more when nothing further crosses, and finally once
// for the best bid and ask. A result waits in its register while rsp_stall holds
// it. Trades come out in fill order, followed by one response item with last set.
// A two-entry queue takes new requests while the engine works.
// ----------------------------------------------------------------------------
// limit_order_book_matcher
// Price-time priority order book with a fixed slot table.
// ----------------------------------------------------------------------------
module limit_order_book_matcher import lobm_pkg::*; #(
  parameter int ORDER_SLOTS = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  logic cmd_valid;
  logic cmd_take;
  cmd_t cmd;

  lobm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .cmd_valid (cmd_valid),
    .cmd_take  (cmd_take),
    .cmd       (cmd)
  );

  lobm_engine #(
    .ORDER_SLOTS (ORDER_SLOTS)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_take  (cmd_take),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  a_trade_nonzero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.is_trade |-> rsp.fill_amt != 32'd0 && !rsp.last)
    else $error("trade transfer with zero fill");

  a_trade_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp.is_trade |-> rsp.trades_made <= TRADES_W'(ORDER_SLOTS))
    else $error("trade count above table size");

  a_take_queued: assert property (@(posedge clk) disable iff (rst)
    cmd_take |-> cmd_valid)
    else $error("command taken from empty queue");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives limit, market, cancel, modify, clear and unused requests into the
// order book matcher, keeps its own copy of the book to work out the trades
// and the response of each request, and checks every transfer that comes out.
// ----------------------------------------------------------------------------
module testbench;
  import lobm_pkg::*;

  localparam int ORDER_SLOTS = 32;
  localparam int WATCHDOG_LIMIT = 40000;
  localparam int RANDOM_ITEMS = 276;
  localparam logic [2:0] OPC_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] OPC_UNUSED_MID = 3'd6;
  localparam logic [2:0] OPC_UNUSED_LAST = 3'd7;

  logic clk;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  limit_order_book_matcher #(.ORDER_SLOTS(ORDER_SLOTS)) i_dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // book copy
  logic        bk_valid [ORDER_SLOTS] = '{default: 1'b0};
  logic [31:0] bk_id [ORDER_SLOTS];
  logic [31:0] bk_trader [ORDER_SLOTS];
  logic        bk_side [ORDER_SLOTS];
  logic [31:0] bk_price [ORDER_SLOTS];
  logic [31:0] bk_qty [ORDER_SLOTS];
  logic [63:0] bk_seq [ORDER_SLOTS];
  logic [63:0] seq_next = '0;
  int          fills_now = 0;

  rsp_t  expected_q [$];
  req_t  pending_q [$];
  int    total_items;
  int    sent_cnt = 0;
  int    mismatch_cnt = 0;
  int    trade_cnt = 0;
  int    response_cnt = 0;
  int    full_reject_cnt = 0;
  int    idle_cnt = 0;
  int    fresh_id;

  task automatic add_expected(input rsp_t t);
    expected_q = {expected_q, t};
  endtask

  task automatic add_pending(input req_t r);
    pending_q = {pending_q, r};
  endtask

  function automatic int find_order(logic [31:0] id);
    for (int i = 0; i < ORDER_SLOTS; i++)
      if (bk_valid[i] && bk_id[i] == id) return i;
    return -1;
  endfunction

  function automatic int best_slot(logic s);
    int b;
    b = -1;
    for (int i = 0; i < ORDER_SLOTS; i++) begin
      if (!bk_valid[i] || bk_side[i] != s) continue;
      if (b < 0) b = i;
      else if (bk_price[i] != bk_price[b]) begin
        if (s == 1'b0 ? bk_price[i] > bk_price[b] : bk_price[i] < bk_price[b]) b = i;
      end else if (bk_seq[i] < bk_seq[b]) b = i;
    end
    return b;
  endfunction

  task automatic cross_book(input logic [31:0] oid, input logic s, input logic [31:0] px,
                            input logic [31:0] qty, input bit mkt, output logic [31:0] rem);
    int m;
    logic [31:0] f;
    rsp_t t;
    bit done;
    rem = qty;
    done = 0;
    while (!done && rem > 0 && fills_now < ORDER_SLOTS) begin
      m = best_slot(~s);
      if (m < 0) done = 1;
      else if (!mkt && (s == 1'b0 ? bk_price[m] > px : bk_price[m] < px)) done = 1;
      else begin
        f = rem < bk_qty[m] ? rem : bk_qty[m];
        t = '0;
        t.is_trade = 1'b1;
        t.subject_ord_id = oid;
        t.maker_ord_id = bk_id[m];
        t.maker_owner_id = bk_trader[m];
        t.trade_price = bk_price[m];
        t.fill_amt = f;
        add_expected(t);
        fills_now++;
        bk_qty[m] -= f;
        rem -= f;
        if (bk_qty[m] == 0) bk_valid[m] = 1'b0;
      end
    end
  endtask

  task automatic rest_order(input logic [31:0] oid, input logic [31:0] tid, input logic s,
                            input logic [31:0] px, input logic [31:0] qty,
                            output logic [2:0] st, output logic [31:0] filled,
                            output logic [31:0] left);
    logic [31:0] rem;
    int fr;
    fr = -1;
    if (find_order(oid) >= 0) begin
      st = ST_REJECTED;
      filled = 0;
      left = 0;
      return;
    end
    cross_book(oid, s, px, qty, 0, rem);
    filled = qty - rem;
    left = rem;
    if (rem == 0) begin
      st = ST_FILLED;
      return;
    end
    for (int i = ORDER_SLOTS - 1; i >= 0; i--)
      if (!bk_valid[i]) fr = i;
    if (fr < 0) begin
      st = ST_REJECTED;
      full_reject_cnt++;
      return;
    end
    bk_valid[fr] = 1'b1;
    bk_id[fr] = oid;
    bk_trader[fr] = tid;
    bk_side[fr] = s;
    bk_price[fr] = px;
    bk_qty[fr] = rem;
    bk_seq[fr] = seq_next;
    seq_next++;
    st = fills_now > 0 ? ST_PARTIAL : ST_ACCEPTED;
  endtask

  task automatic predict_request(input req_t r);
    logic [2:0] st;
    logic [31:0] filled, left;
    int s;
    rsp_t t;
    st = ST_REJECTED;
    filled = 0;
    left = 0;
    fills_now = 0;
    case (r.op)
      OPC_LIMIT: begin
        rest_order(r.ord_id, r.owner_id, r.side, r.price, r.qty, st, filled, left);
      end
      OPC_MARKET: begin
        cross_book(r.ord_id, r.side, 32'd0, r.qty, 1, left);
        filled = r.qty - left;
        st = left == 0 ? ST_FILLED : ST_PARTIAL;
      end
      OPC_CANCEL: begin
        s = find_order(r.ord_id);
        if (s < 0) st = ST_NOT_FOUND;
        else begin
          left = bk_qty[s];
          bk_valid[s] = 1'b0;
          st = ST_CANCELLED;
        end
      end
      OPC_MODIFY: begin
        s = find_order(r.ord_id);
        if (s < 0) st = ST_NOT_FOUND;
        else if (r.price != 0 && r.price != bk_price[s]) begin
          bk_valid[s] = 1'b0;
          rest_order(r.ord_id, bk_trader[s], bk_side[s], r.price, r.qty, st, filled, left);
        end else if (r.qty == 0) begin
          left = bk_qty[s];
          bk_valid[s] = 1'b0;
          st = ST_CANCELLED;
        end else if (r.qty < bk_qty[s]) begin
          bk_qty[s] = r.qty;
          left = r.qty;
          st = ST_MODIFIED;
        end else begin
          bk_valid[s] = 1'b0;
          rest_order(r.ord_id, bk_trader[s], bk_side[s], bk_price[s], r.qty,
                     st, filled, left);
        end
      end
      OPC_CLEAR: begin
        for (int i = 0; i < ORDER_SLOTS; i++) bk_valid[i] = 1'b0;
        st = ST_ACCEPTED;
      end
      default: st = ST_REJECTED;
    endcase
    t = '0;
    t.subject_ord_id = r.ord_id;
    t.fill_amt = filled;
    t.status = st;
    t.qty_left = left;
    t.trades_made = fills_now[TRADES_W-1:0];
    s = best_slot(1'b0);
    if (s >= 0) t.top_bid = bk_price[s];
    s = best_slot(1'b1);
    if (s >= 0) t.top_ask = bk_price[s];
    t.last = 1'b1;
    add_expected(t);
  endtask

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t: %s got %0h expected %0h", $realtime, field, got, want);
    mismatch_cnt++;
  endtask

  task automatic check_result(input rsp_t got);
    rsp_t w;
    if (expected_q.size() == 0) begin
      report_mismatch("unexpected transfer, subject", 64'(got.subject_ord_id), 64'd0);
      return;
    end
    w = expected_q.pop_front();
    if (got.is_trade !== w.is_trade)
      report_mismatch("is_trade", 64'(got.is_trade), 64'(w.is_trade));
    if (got.subject_ord_id !== w.subject_ord_id)
      report_mismatch("subject_ord_id", 64'(got.subject_ord_id), 64'(w.subject_ord_id));
    if (got.maker_ord_id !== w.maker_ord_id)
      report_mismatch("maker_ord_id", 64'(got.maker_ord_id), 64'(w.maker_ord_id));
    if (got.maker_owner_id !== w.maker_owner_id)
      report_mismatch("maker_owner_id", 64'(got.maker_owner_id), 64'(w.maker_owner_id));
    if (got.trade_price !== w.trade_price)
      report_mismatch("trade_price", 64'(got.trade_price), 64'(w.trade_price));
    if (got.fill_amt !== w.fill_amt)
      report_mismatch("fill_amt", 64'(got.fill_amt), 64'(w.fill_amt));
    if (got.status !== w.status) report_mismatch("status", 64'(got.status), 64'(w.status));
    if (got.qty_left !== w.qty_left)
      report_mismatch("qty_left", 64'(got.qty_left), 64'(w.qty_left));
    if (got.trades_made !== w.trades_made)
      report_mismatch("trades_made", 64'(got.trades_made), 64'(w.trades_made));
    if (got.top_bid !== w.top_bid)
      report_mismatch("top_bid", 64'(got.top_bid), 64'(w.top_bid));
    if (got.top_ask !== w.top_ask)
      report_mismatch("top_ask", 64'(got.top_ask), 64'(w.top_ask));
    if (got.last !== w.last) report_mismatch("last", 64'(got.last), 64'(w.last));
    if (w.is_trade) trade_cnt++;
    else response_cnt++;
  endtask

  function automatic req_t make_req(logic [2:0] op, logic [31:0] oid, logic [31:0] tid,
                                    logic s, logic [31:0] px, logic [31:0] qty);
    req_t r;
    r.op = op;
    r.ord_id = oid;
    r.owner_id = tid;
    r.side = s;
    r.price = px;
    r.qty = qty;
    return r;
  endfunction

  function automatic req_t random_req();
    req_t r;
    int pick;
    r.ord_id = $urandom_range(9) == 0 ? $urandom() : $urandom_range(40);
    r.owner_id = $urandom_range(3) == 0 ? $urandom() : $urandom_range(7);
    r.side = 1'($urandom_range(1));
    pick = $urandom_range(19);
    r.price = pick == 0 ? $urandom() : (pick == 1 ? 32'd0 : 1000 + $urandom_range(12));
    pick = $urandom_range(19);
    r.qty = pick == 0 ? $urandom() : (pick == 1 ? 32'd0 : $urandom_range(1, 25));
    pick = $urandom_range(99);
    if (pick < 42) r.op = OPC_LIMIT;
    else if (pick < 52) r.op = OPC_MARKET;
    else if (pick < 67) r.op = OPC_CANCEL;
    else if (pick < 93) r.op = OPC_MODIFY;
    else if (pick < 96) r.op = OPC_CLEAR;
    else r.op = 3'($urandom_range(OPC_UNUSED_FIRST, OPC_UNUSED_LAST));
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    int idle_pct;
    bit take;
    take = 0;
    idle_pct = sent_cnt * 3 < total_items ? 26 : (sent_cnt * 3 < total_items * 2 ? 80 : 0);
    if (!rst) begin
      if (req_valid && !req_stall) begin
        predict_request(req);
        sent_cnt++;
        take = 1;
      end
      if (!req_valid || take) begin
        if (pending_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
          req_valid <= 1'b1;
          req <= pending_q.pop_front();
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    int stall_pct;
    stall_pct = sent_cnt * 3 < total_items ? 80 : (sent_cnt * 3 < total_items * 2 ? 26 : 0);
    if (!rst) begin
      if (rsp_valid && !rsp_stall) check_result(rsp);
      rsp_stall <= $urandom_range(99) < stall_pct;
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
        (pending_q.size() == 0 && !req_valid && expected_q.size() == 0)) begin
      idle_cnt <= 0;
    end else if (idle_cnt >= WATCHDOG_LIMIT) begin
      $display("watchdog expired with %0d results outstanding", expected_q.size());
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cnt <= idle_cnt + 1;
    end
  end

  initial begin
    logic [31:0] ones;
    int burst_px;
    ones = '1;
    fresh_id = 5000;

    // directed part
    add_pending(make_req(OPC_CLEAR, 32'd0, 32'd0, 1'b0, 32'd0, 32'd0));
    add_pending(make_req(OPC_LIMIT, 32'd1, 32'd11, 1'b0, 32'd100, 32'd10));
    add_pending(make_req(OPC_LIMIT, 32'd2, 32'd12, 1'b0, 32'd100, 32'd5));
    add_pending(make_req(OPC_LIMIT, 32'd3, 32'd13, 1'b1, 32'd101, 32'd3));
    add_pending(make_req(OPC_LIMIT, 32'd1, 32'd14, 1'b1, 32'd200, 32'd4));
    add_pending(make_req(OPC_LIMIT, 32'd4, 32'd14, 1'b1, 32'd99, 32'd12));
    add_pending(make_req(OPC_MARKET, 32'd5, 32'd15, 1'b0, 32'd0, 32'd10));
    add_pending(make_req(OPC_MARKET, 32'd6, 32'd15, 1'b1, 32'd0, 32'd0));
    add_pending(make_req(OPC_LIMIT, 32'd7, 32'd15, 1'b1, 32'd90, 32'd0));
    add_pending(make_req(OPC_CANCEL, 32'd2, 32'd0, 1'b0, 32'd0, 32'd0));
    add_pending(make_req(OPC_CANCEL, 32'd77, 32'd0, 1'b0, 32'd0, 32'd0));
    add_pending(make_req(OPC_MODIFY, 32'd78, 32'd0, 1'b0, 32'd5, 32'd5));
    add_pending(make_req(OPC_LIMIT, 32'd8, 32'd16, 1'b0, 32'd50, 32'd20));
    add_pending(make_req(OPC_MODIFY, 32'd8, 32'd0, 1'b1, 32'd0, 32'd10));
    add_pending(make_req(OPC_MODIFY, 32'd8, 32'd0, 1'b1, 32'd50, 32'd30));
    add_pending(make_req(OPC_MODIFY, 32'd8, 32'd0, 1'b1, 32'd60, 32'd30));
    add_pending(make_req(OPC_MODIFY, 32'd8, 32'd0, 1'b0, 32'd0, 32'd0));
    add_pending(make_req(OPC_UNUSED_FIRST, ones, ones, 1'b1, ones, ones));
    add_pending(make_req(OPC_UNUSED_MID, 32'd9, 32'd9, 1'b0, 32'd9, 32'd9));
    add_pending(make_req(OPC_UNUSED_LAST, 32'd9, 32'd9, 1'b0, 32'd9, 32'd9));
    add_pending(make_req(OPC_LIMIT, ones, ones, 1'b1, ones, ones));
    add_pending(make_req(OPC_LIMIT, 32'd0, 32'd0, 1'b0, 32'd0, 32'd7));
    add_pending(make_req(OPC_MARKET, 32'd10, 32'd1, 1'b0, 32'd0, ones));
    add_pending(make_req(OPC_CLEAR, ones, 32'd0, 1'b0, 32'd0, 32'd0));

    // random part, with bursts that fill the book and then cross it
    while (pending_q.size() < RANDOM_ITEMS + 24) begin
      if ($urandom_range(39) == 0) begin
        burst_px = 500 + $urandom_range(20);
        for (int i = 0; i < ORDER_SLOTS + 2; i++) begin
          add_pending(make_req(OPC_LIMIT, fresh_id, $urandom_range(7), 1'b1,
                               burst_px + $urandom_range(3), $urandom_range(1, 4)));
          fresh_id++;
        end
        add_pending(make_req(OPC_LIMIT, fresh_id, 32'd3, 1'b1, 32'd2000, 32'd5));
        add_pending(make_req(OPC_MARKET, fresh_id + 1, 32'd3, 1'b0, 32'd0, 32'd400));
        fresh_id += 2;
      end else begin
        add_pending(random_req());
      end
    end
    total_items = pending_q.size();

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    while (pending_q.size() > 0 || req_valid || expected_q.size() > 0) @(posedge clk);
    repeat (300) @(posedge clk);

    $display("%0d requests sent, %0d trades and %0d responses checked", sent_cnt, trade_cnt,
             response_cnt);
    $display("book-full rejects seen: %0d", full_reject_cnt);
    if (mismatch_cnt == 0 && expected_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
